>>> hdl/clmd_pkg.sv
// ----------------------------------------------------------------------------
// clmd_pkg: shared types and constants of the Content-Length deframer
// Holds the item and result types, the header key text, the character codes
// and the per-character header line scanner.
// ----------------------------------------------------------------------------
package clmd_pkg;

    // Default width of the content length and of the body counter.
    localparam int LEN_BITS_DEF = 32;

    typedef enum logic [1:0] {
        EV_BODY  = 2'd0,
        EV_EMPTY = 2'd1,
        EV_ERROR = 2'd2,
        EV_ABORT = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        VP_SKIP   = 2'd0,
        VP_SIGN   = 2'd1,
        VP_DIGITS = 2'd2,
        VP_DONE   = 2'd3
    } t_vphase;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] body_byte;
        logic       last;
    } t_result;

    // Scan state of the current header line, without the digit accumulator.
    typedef struct packed {
        logic       nonempty;
        logic [3:0] prefix_pos;
        logic       failed;
        t_vphase    phase;
        logic       negative;
    } t_line;

    localparam t_line LINE_CLEAR = '{1'b0, 4'd0, 1'b0, VP_SKIP, 1'b0};

    localparam logic [3:0] KEY_LEN = 4'd15;

    // Header key, padded to a power of two so a 4-bit position indexes it.
    localparam logic [7:0] KEY_TEXT [16] = '{
        "C", "o", "n", "t", "e", "n", "t", "-",
        "L", "e", "n", "g", "t", "h", ":", 8'h00
    };

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam int DEC_BASE = 10;

    // Advances the line scan by one content character. The take output says
    // that the character is a digit that goes into the length accumulator.
    function automatic t_line scan_char(input t_line st, input logic [7:0] c,
                                        output logic take);
        t_line nx;
        logic  digit;
        logic  ws;
        nx    = st;
        take  = 1'b0;
        digit = (c >= CH_0) && (c <= CH_9);
        ws    = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
        nx.nonempty = 1'b1;
        if (!st.failed) begin
            if (st.prefix_pos != KEY_LEN) begin
                if (c == KEY_TEXT[st.prefix_pos]) begin
                    nx.prefix_pos = 4'(st.prefix_pos + 4'd1);
                end else begin
                    nx.failed = 1'b1;
                end
            end else if ((st.phase == VP_SKIP) && ws) begin
                nx.phase = VP_SKIP;
            end else if ((st.phase == VP_SKIP) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
                nx.negative = (c == CH_MINUS);
                nx.phase    = VP_SIGN;
            end else if ((st.phase != VP_DONE) && digit) begin
                take     = 1'b1;
                nx.phase = VP_DIGITS;
            end else begin
                nx.phase = VP_DONE;
            end
        end
        return nx;
    endfunction

endpackage

>>> hdl/clmd_if.sv
// ----------------------------------------------------------------------------
// clmd_if: request channels of the Content-Length deframer
// The stream channel carries input bytes and end-of-stream markers; the
// result channel carries body bytes and message events.
// ----------------------------------------------------------------------------
interface clmd_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data;

    modport source (output valid, output kind, output data, input ready);
    modport sink   (input valid, input kind, input data, output ready);
endinterface

interface clmd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] body_byte;
    logic       last;

    modport source (output valid, output event_res, output body_byte, output last,
                    input ready);
    modport sink   (input valid, input event_res, input body_byte, input last,
                     output ready);
endinterface

>>> hdl/clmd_core.sv
// ----------------------------------------------------------------------------
// clmd_core: deframing state and single-pass update
// Holds the header and body state and turns one stream request into at most
// one result in the cycle in which it is stepped.
// ----------------------------------------------------------------------------
module clmd_core
    import clmd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam int MAG_W = LEN_BITS + 4;

    logic                r_in_body,    n_in_body;
    logic                r_pending_cr, n_pending_cr;
    t_line               r_line,       n_line;
    logic [LEN_BITS-1:0] r_mag,        n_mag;
    logic                r_have_len,   n_have_len;
    logic                r_len_neg,    n_len_neg;
    logic [LEN_BITS-1:0] r_rem,        n_rem;

    t_line               v_line_cr;
    t_line               v_line_c;
    logic                v_take_cr;
    logic                v_take_c;
    logic                v_take;
    logic [3:0]          v_digit;
    logic [MAG_W-1:0]    v_wide;
    logic [LEN_BITS-1:0] v_mag_acc;
    logic [LEN_BITS-1:0] v_rem_dec;
    logic [7:0]          v_c;

    assign v_c = i_item.data;

    // Character scan for both the plain path and the lone-CR path, where the
    // CR and its follower both count as content.
    always_comb begin
        v_line_cr = scan_char(r_line, CH_CR, v_take_cr);
        if (r_pending_cr) begin
            v_line_c = scan_char(v_line_cr, v_c, v_take_c);
        end else begin
            v_line_c = scan_char(r_line, v_c, v_take_c);
        end
        // A CR is never a digit, so only the follower can feed the accumulator.
        v_take = v_take_c | (r_pending_cr & v_take_cr);
    end

    // Decimal accumulate with saturation at the all-ones length.
    always_comb begin
        v_digit = 4'(v_c - CH_0);
        v_wide  = MAG_W'({4'd0, r_mag}) * MAG_W'(DEC_BASE) + MAG_W'(v_digit);
        if (v_wide[MAG_W-1:LEN_BITS] != 4'd0) begin
            v_mag_acc = '1;
        end else begin
            v_mag_acc = v_wide[LEN_BITS-1:0];
        end
        v_rem_dec = (r_rem != '0) ? LEN_BITS'(r_rem - 1'b1) : r_rem;
    end

    always_comb begin
        n_in_body    = r_in_body;
        n_pending_cr = r_pending_cr;
        n_line       = r_line;
        n_mag        = r_mag;
        n_have_len   = r_have_len;
        n_len_neg    = r_len_neg;
        n_rem        = r_rem;
        o_res_valid  = 1'b0;
        o_res        = '{EV_BODY, 8'd0, 1'b0};

        if (i_item.kind) begin
            o_res_valid  = 1'b1;
            o_res        = '{EV_ABORT, 8'd0, 1'b0};
            n_in_body    = 1'b0;
            n_pending_cr = 1'b0;
            n_line       = LINE_CLEAR;
            n_mag        = '0;
            n_have_len   = 1'b0;
            n_len_neg    = 1'b0;
            n_rem        = '0;
        end else if (r_in_body) begin
            o_res_valid = 1'b1;
            o_res       = '{EV_BODY, v_c, 1'b0};
            n_rem       = v_rem_dec;
            if (v_rem_dec == '0) begin
                o_res.last = 1'b1;
                n_in_body  = 1'b0;
                n_line     = LINE_CLEAR;
                n_mag      = '0;
                n_have_len = 1'b0;
                n_len_neg  = 1'b0;
            end
        end else if (r_pending_cr && (v_c == CH_LF)) begin
            n_pending_cr = 1'b0;
            n_line       = LINE_CLEAR;
            n_mag        = '0;
            if (r_line.nonempty) begin
                if (!r_line.failed && (r_line.prefix_pos == KEY_LEN)) begin
                    n_have_len = 1'b1;
                    n_len_neg  = r_line.negative && (r_mag != '0);
                    n_rem      = r_mag;
                end
            end else if (!r_have_len || r_len_neg) begin
                o_res_valid = 1'b1;
                o_res       = '{EV_ERROR, 8'd0, 1'b0};
                n_rem       = '0;
                n_have_len  = 1'b0;
                n_len_neg   = 1'b0;
            end else if (r_rem == '0) begin
                o_res_valid = 1'b1;
                o_res       = '{EV_EMPTY, 8'd0, 1'b0};
                n_have_len  = 1'b0;
                n_len_neg   = 1'b0;
            end else begin
                n_have_len = 1'b0;
                n_in_body  = 1'b1;
            end
        end else if (!r_pending_cr && (v_c == CH_CR)) begin
            n_pending_cr = 1'b1;
        end else begin
            n_pending_cr = 1'b0;
            n_line       = v_line_c;
            if (v_take) begin
                n_mag = v_mag_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body    <= 1'b0;
            r_pending_cr <= 1'b0;
            r_line       <= LINE_CLEAR;
            r_mag        <= '0;
            r_have_len   <= 1'b0;
            r_len_neg    <= 1'b0;
            r_rem        <= '0;
        end else if (i_step) begin
            r_in_body    <= n_in_body;
            r_pending_cr <= n_pending_cr;
            r_line       <= n_line;
            r_mag        <= n_mag;
            r_have_len   <= n_have_len;
            r_len_neg    <= n_len_neg;
            r_rem        <= n_rem;
        end
    end

endmodule

>>> hdl/content_length_message_deframer_top.sv
// ----------------------------------------------------------------------------
// content_length_message_deframer_top: Content-Length message deframer
// Splits a byte stream into header blocks and length-delimited bodies.
// ----------------------------------------------------------------------------
// The deframer takes one stream request per clock cycle, without gaps, as
// long as the result side keeps taking results. Each request is either a
// stream byte or an end-of-stream marker. Header lines end in CR LF and the
// header block ends at an empty line; the last line that starts with the
// case-sensitive key "Content-Length:" sets the body length, read like a C
// strtoll (leading white space, optional sign, decimal digits), saturating
// at the all-ones value of LEN_BITS bits. The body bytes that follow come
// out one result each, the final one with last set. A header block without
// a length, or with a negative one, gives an error event; a zero length gives
// an empty-message event. An end-of-stream marker always gives an abort event
// and returns the block to its reset state; a body that was partly delivered
// must then be dropped downstream. Header bytes and the end of a non-empty
// header line give no result. A request passes an input register and then
// the single-pass state update into a result register, from which its
// result is presented to the sink. The input ready follows the result
// ready in the same cycle whenever both registers are full, so throughput
// is one request per cycle, limited only by the result side.
// ----------------------------------------------------------------------------
module content_length_message_deframer_top
    import clmd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    clmd_in_if.sink    i_in,
    clmd_out_if.source o_out
);

    // Input register: holds one accepted stream request.
    logic    r_in_valid;
    t_item   r_in_item;

    // Result register: holds one result until the sink takes it.
    logic    r_out_valid;
    t_result r_out_res;

    logic    w_step;
    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;

    // The held request is processed when the result register is free or is
    // being emptied in this same cycle.
    assign w_step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_step;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= '{i_in.kind, i_in.data};
        end
    end

    clmd_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_item      (r_in_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_out_res <= w_res;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.event_res = r_out_res.event_res;
    assign o_out.body_byte = r_out_res.body_byte;
    assign o_out.last      = r_out_res.last;

    // An end-of-stream request always leaves an abort result behind it.
    a_abort_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_item.kind) |=> (r_out_valid && (r_out_res.event_res == EV_ABORT)))
        else $error("end-of-stream request did not produce an abort result");

    // With the result register empty, the stream side is never held off.
    a_ready_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("stream side stalled while the result register was free");

    // Both registers full and the sink stalling: no new request may enter.
    a_hold_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("request accepted while both registers were full");

    // The last flag only ever marks a body byte.
    a_last_on_body : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_res_valid && w_res.last) |=> (r_out_res.event_res == EV_BODY))
        else $error("last flag set on a result that is not a body byte");

endmodule

>>> tb/sv/content_length_message_deframer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// content_length_message_deframer_top_tb: self-checking bench of the deframer
// Drives header blocks, length lines of every shape, bodies, noise and
// end-of-stream markers, predicts each result in the bench and compares
// every result the deframer delivers, field by field, in order.
// ----------------------------------------------------------------------------
module content_length_message_deframer_top_tb;
    import clmd_pkg::*;

    // Number of stream requests the run aims at before it winds down.
    localparam int ITEM_TARGET = 550;
    // Cycles without any accepted request, on either side, before giving up.
    localparam int STUCK_LIMIT = 2000;
    // Results trail their request through the pipeline; the tail wait is generous.
    localparam int DRAIN_CYCLES = 10;
    // Number of stream requests sent at full rate, with no idling anywhere.
    localparam int QUIET_ITEMS = 120;

    localparam int KEY_CHARS = 15;
    localparam logic [8*KEY_CHARS-1:0] LENGTH_KEY = "Content-Length:";
    localparam longint unsigned LENGTH_CEILING = (64'd1 << LEN_BITS_DEF) - 64'd1;

    // Shapes of the value on a Content-Length line.
    typedef enum int {
        FORM_PLAIN,
        FORM_SIGNED,
        FORM_JUNK_TAIL,
        FORM_ZERO,
        FORM_NEG_ZERO,
        FORM_NEGATIVE,
        FORM_NO_DIGITS,
        FORM_MISSING,
        FORM_OVERFLOW,
        FORM_COUNT
    } t_frame_form;

    logic i_clk;
    logic i_rst_n;

    clmd_in_if  in_if ();
    clmd_out_if out_if ();

    content_length_message_deframer_top #(
        .LEN_BITS (LEN_BITS_DEF)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Bench copy of the deframer state. It is advanced once per accepted
    // stream request, in the monitor below, so it always mirrors what the
    // deframer has seen so far.
    // ------------------------------------------------------------------------
    logic            body_phase;     // inside a body
    logic            cr_open;        // a CR waits for its follower
    logic            line_has_text;  // current header line is not empty
    int              key_matched;    // key characters matched so far
    logic            key_mismatch;   // current line does not start with the key
    t_vphase         value_state;    // where the value scan stands
    logic            value_minus;    // a minus sign was read
    longint unsigned value_digits;   // magnitude read so far, saturated
    logic            length_known;   // a key line was seen in this block
    logic            length_below_zero;
    longint unsigned body_left;      // header length, then bytes still to come

    t_result expected_results[$];

    int   items_sent;
    int   results_checked;
    int   error_count;
    int   stuck_cycles;
    int   event_tally [4];
    logic stall_on;

    logic [7:0] frame_q[$];
    t_result    want;

    function automatic logic [7:0] key_byte(input int pos);
        return LENGTH_KEY[8*(KEY_CHARS-1-pos) +: 8];
    endfunction

    function automatic void note_failure(input string what);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", what);
        end
    endfunction

    function automatic void expect_result(input t_event ev, input logic [7:0] b,
                                          input logic last);
        t_result r;
        r.event_res = ev;
        r.body_byte = b;
        r.last      = last;
        expected_results.insert(expected_results.size(), r);
        event_tally[ev]++;
    endfunction

    function automatic void clear_line_scan();
        line_has_text = 1'b0;
        key_matched   = 0;
        key_mismatch  = 1'b0;
        value_state   = VP_SKIP;
        value_minus   = 1'b0;
        value_digits  = 64'd0;
    endfunction

    function automatic void reset_prediction();
        body_phase        = 1'b0;
        cr_open           = 1'b0;
        length_known      = 1'b0;
        length_below_zero = 1'b0;
        body_left         = 64'd0;
        clear_line_scan();
    endfunction

    // The value is read the way strtoll reads it: white space, one sign,
    // then digits; anything else ends the scan for the rest of the line.
    function automatic void scan_value(input logic [7:0] c);
        logic            is_digit;
        logic            is_space;
        longint unsigned d;
        is_digit = (c >= CH_0) && (c <= CH_9);
        is_space = (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
        d        = 64'(c) - 64'(CH_0);
        if ((value_state == VP_SKIP) && is_space) begin
            // Leading white space is skipped.
        end else if ((value_state == VP_SKIP) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
            value_minus = (c == CH_MINUS);
            value_state = VP_SIGN;
        end else if ((value_state != VP_DONE) && is_digit) begin
            if (value_digits > (LENGTH_CEILING - d) / 64'(DEC_BASE)) begin
                value_digits = LENGTH_CEILING;
            end else begin
                value_digits = value_digits * 64'(DEC_BASE) + d;
            end
            value_state = VP_DIGITS;
        end else begin
            value_state = VP_DONE;
        end
    endfunction

    function automatic void scan_content(input logic [7:0] c);
        line_has_text = 1'b1;
        if (!key_mismatch) begin
            if (key_matched < KEY_CHARS) begin
                if (c == key_byte(key_matched)) begin
                    key_matched++;
                end else begin
                    key_mismatch = 1'b1;
                end
            end else begin
                scan_value(c);
            end
        end
    endfunction

    // A CR LF closes a line; an empty line closes the header block.
    function automatic void finish_line();
        if (line_has_text) begin
            if (!key_mismatch && (key_matched == KEY_CHARS)) begin
                length_known      = 1'b1;
                length_below_zero = value_minus && (value_digits != 64'd0);
                body_left         = value_digits;
            end
            clear_line_scan();
        end else begin
            clear_line_scan();
            if (!length_known || length_below_zero) begin
                expect_result(EV_ERROR, 8'h00, 1'b0);
                body_left         = 64'd0;
                length_known      = 1'b0;
                length_below_zero = 1'b0;
            end else if (body_left == 64'd0) begin
                expect_result(EV_EMPTY, 8'h00, 1'b0);
                length_known      = 1'b0;
                length_below_zero = 1'b0;
            end else begin
                length_known = 1'b0;
                body_phase   = 1'b1;
            end
        end
    endfunction

    function automatic void predict_request(input logic kind, input logic [7:0] c);
        if (kind) begin
            reset_prediction();
            expect_result(EV_ABORT, 8'h00, 1'b0);
        end else if (body_phase) begin
            if (body_left > 64'd0) begin
                body_left--;
            end
            if (body_left == 64'd0) begin
                expect_result(EV_BODY, c, 1'b1);
                reset_prediction();
            end else begin
                expect_result(EV_BODY, c, 1'b0);
            end
        end else if (cr_open) begin
            // The follower of a lone CR is line content, even another CR.
            cr_open = 1'b0;
            if (c == CH_LF) begin
                finish_line();
            end else begin
                scan_content(CH_CR);
                scan_content(c);
            end
        end else if (c == CH_CR) begin
            cr_open = 1'b1;
        end else begin
            scan_content(c);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor. Results are checked before the request of the same edge is
    // predicted; a result always trails its request, so the order inside
    // the block keeps the comparison exact. The watchdog closes the run when
    // neither side has moved a request for too long.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: event %0d byte %02h last %0b",
                                           out_if.event_res, out_if.body_byte, out_if.last));
                end else begin
                    want = expected_results.pop_front();
                    if ((out_if.event_res !== want.event_res) ||
                        (out_if.body_byte !== want.body_byte) ||
                        (out_if.last !== want.last)) begin
                        note_failure($sformatf(
                            "mismatch (event/byte/last): expected %0d/%02h/%0b, got %0d/%02h/%0b",
                            want.event_res, want.body_byte, want.last,
                            out_if.event_res, out_if.body_byte, out_if.last));
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                predict_request(in_if.kind, in_if.data);
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("watchdog: no request moved for %0d cycles", STUCK_LIMIT);
                    $display("content_length_message_deframer_top test failed");
                    $finish;
                end
            end
        end
    end

    // Result side: takes results at random while idling is on.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= !stall_on || ($urandom_range(99) >= 38);
        end
    end

    // ------------------------------------------------------------------------
    // Stream side.
    // ------------------------------------------------------------------------

    // Offers one request and returns at the edge that takes it. Valid stays
    // high from one request to the next unless an idle cycle is drawn.
    task automatic send_item(input logic kind, input logic [7:0] data);
        while (stall_on && ($urandom_range(99) < 38)) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.kind  <= kind;
        in_if.data  <= data;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // Holds the stream back until every predicted result has come out.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic void put_byte(input logic [7:0] b);
        frame_q.insert(frame_q.size(), b);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endfunction

    function automatic void put_line_end();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    function automatic void put_key();
        for (int i = 0; i < KEY_CHARS; i++) begin
            put_byte(key_byte(i));
        end
    endfunction

    // Every white space character that strtoll skips, except CR, which would
    // open a CR pair of its own.
    function automatic void put_spaces();
        repeat ($urandom_range(2)) begin
            case ($urandom_range(4))
                0:       put_byte(CH_SP);
                1:       put_byte(CH_TAB);
                2:       put_byte(CH_LF);
                3:       put_byte(8'h0B);
                default: put_byte(8'h0C);
            endcase
        end
    endfunction

    // A header line that never sets the length: random bytes, a key with one
    // character off, or a key cut short. A CR inside it is always followed by
    // something other than LF, so the line cannot end early.
    function automatic void put_filler_line();
        int         pos;
        logic [7:0] b;
        case ($urandom_range(3))
            0: begin
                pos = $urandom_range(KEY_CHARS - 1);
                for (int i = 0; i < KEY_CHARS; i++) begin
                    put_byte((i == pos) ? (key_byte(i) ^ 8'h20) : key_byte(i));
                end
                put_text(" 7");
            end
            1: begin
                pos = $urandom_range(KEY_CHARS - 1, 1);
                for (int i = 0; i < pos; i++) begin
                    put_byte(key_byte(i));
                end
            end
            default: begin
                repeat ($urandom_range(10, 1)) begin
                    b = 8'($urandom_range(255));
                    put_byte(b);
                    if (b == CH_CR) begin
                        b = 8'($urandom_range(255));
                        while (b == CH_LF) begin
                            b = 8'($urandom_range(255));
                        end
                        put_byte(b);
                    end
                end
            end
        endcase
        put_line_end();
    endfunction

    function automatic t_frame_form pick_form();
        int r;
        r = $urandom_range(99);
        if (r < 35) return FORM_PLAIN;
        if (r < 45) return FORM_SIGNED;
        if (r < 55) return FORM_JUNK_TAIL;
        if (r < 62) return FORM_ZERO;
        if (r < 68) return FORM_NEG_ZERO;
        if (r < 76) return FORM_NEGATIVE;
        if (r < 83) return FORM_NO_DIGITS;
        if (r < 90) return FORM_MISSING;
        return FORM_OVERFLOW;
    endfunction

    // Builds and sends one message: filler lines, maybe an early length line
    // that the last one overrides, the length line in the given shape, the
    // empty line and the body. A saturated length cannot be sent out in
    // full, so its body is cut by an end-of-stream marker. When cut_short is
    // set, the message loses its tail and an end-of-stream marker follows.
    task automatic send_message(input t_frame_form form, input bit cut_short);
        int body_len;
        body_len = 0;
        repeat ($urandom_range(2)) put_filler_line();
        if ((form != FORM_MISSING) && ($urandom_range(3) == 0)) begin
            put_key();
            if ($urandom_range(1) == 0) begin
                put_byte(CH_MINUS);
            end
            put_text($sformatf("%0d", $urandom_range(50)));
            put_line_end();
            if ($urandom_range(1) == 0) begin
                put_filler_line();
            end
        end
        if (form != FORM_MISSING) begin
            put_key();
            put_spaces();
            case (form)
                FORM_PLAIN: begin
                    body_len = ($urandom_range(7) == 0) ? $urandom_range(40, 9)
                                                        : $urandom_range(8, 1);
                    repeat ($urandom_range(2)) put_byte(CH_0);
                    put_text($sformatf("%0d", body_len));
                end
                FORM_SIGNED: begin
                    body_len = $urandom_range(8, 1);
                    put_byte(CH_PLUS);
                    put_text($sformatf("%0d", body_len));
                end
                FORM_JUNK_TAIL: begin
                    // Digits after the first non-digit no longer count.
                    body_len = $urandom_range(8, 1);
                    put_text($sformatf("%0d", body_len));
                    put_byte(($urandom_range(1) == 0) ? CH_SP : 8'h78);
                    put_byte(8'(CH_0 + $urandom_range(9)));
                end
                FORM_ZERO: begin
                    repeat ($urandom_range(3, 1)) put_byte(CH_0);
                end
                FORM_NEG_ZERO: begin
                    put_byte(CH_MINUS);
                    repeat ($urandom_range(2, 1)) put_byte(CH_0);
                end
                FORM_NEGATIVE: begin
                    put_byte(CH_MINUS);
                    put_text($sformatf("%0d", $urandom_range(999, 1)));
                end
                FORM_NO_DIGITS: begin
                    case ($urandom_range(3))
                        0:       put_byte(CH_PLUS);
                        1:       put_byte(CH_MINUS);
                        2:       put_text("x12");
                        default: ;
                    endcase
                end
                default: begin
                    // Ten or more digits led by 5..9 lie past the 32-bit ceiling.
                    put_byte(8'(CH_0 + $urandom_range(9, 5)));
                    repeat ($urandom_range(19, 9)) put_byte(8'(CH_0 + $urandom_range(9)));
                    body_len = $urandom_range(4, 1);
                end
            endcase
            put_line_end();
        end
        put_line_end();
        repeat (body_len) put_byte(8'($urandom_range(255)));
        if (cut_short) begin
            repeat ($urandom_range(frame_q.size() - 1, 1)) void'(frame_q.pop_back());
        end
        for (int i = 0; i < frame_q.size(); i++) begin
            send_item(1'b0, frame_q[i]);
        end
        frame_q.delete();
        if (cut_short || (form == FORM_OVERFLOW)) begin
            send_item(1'b1, 8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Line framing without any length: an empty first line, the extreme byte
    // values as content, a lone CR whose follower is another CR, and bare LFs
    // both inside a line and at its start. Each header block ends in error.
    task automatic test_line_framing();
        put_line_end();
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_CR);
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_line_end();
        put_line_end();
        put_byte(CH_LF);
        put_line_end();
        put_line_end();
        for (int i = 0; i < frame_q.size(); i++) begin
            send_item(1'b0, frame_q[i]);
        end
        frame_q.delete();
        wait_drained();
    endtask

    // End of stream at rest and with a CR left open, then an empty line that
    // must find no length left over from before.
    task automatic test_end_of_stream();
        send_item(1'b1, 8'hFF);
        send_item(1'b0, key_byte(0));
        send_item(1'b0, key_byte(1));
        send_item(1'b0, CH_CR);
        send_item(1'b1, 8'h00);
        send_item(1'b0, CH_CR);
        send_item(1'b0, CH_LF);
        wait_drained();
    endtask

    // One message of every length shape, with random content around it.
    task automatic test_length_forms();
        for (int f = 0; f < FORM_COUNT; f++) begin
            send_message(t_frame_form'(f), 1'b0);
        end
        wait_drained();
    endtask

    // Mostly well-formed messages, with cut messages, noise and bare markers
    // mixed in. The first stretch runs at full rate on both sides; then the
    // stream pauses until every result is out, and idling starts.
    task automatic test_random_stream();
        int quiet_end;
        int pick;
        quiet_end = items_sent + QUIET_ITEMS;
        stall_on  = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            if (!stall_on && (items_sent >= quiet_end)) begin
                wait_drained();
                stall_on = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_message(pick_form(), 1'b0);
            end else if (pick < 80) begin
                send_message(pick_form(), 1'b1);
            end else if (pick < 92) begin
                repeat ($urandom_range(12, 1)) send_item(1'b0, 8'($urandom_range(255)));
                send_item(1'b1, 8'($urandom_range(255)));
            end else begin
                send_item(1'b1, 8'($urandom_range(255)));
            end
        end
        wait_drained();
    endtask

    initial begin
        in_if.valid     <= 1'b0;
        in_if.kind      <= 1'b0;
        in_if.data      <= 8'h00;
        i_rst_n         <= 1'b0;
        stall_on        = 1'b1;
        items_sent      = 0;
        results_checked = 0;
        error_count     = 0;
        stuck_cycles    = 0;
        for (int i = 0; i < 4; i++) begin
            event_tally[i] = 0;
        end
        reset_prediction();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_line_framing();
        test_end_of_stream();
        test_length_forms();
        test_random_stream();

        // Header bytes give no result, so let the pipeline run empty too.
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d stream requests and checked %0d results, %0d of them body bytes.",
                 items_sent, results_checked, event_tally[EV_BODY]);
        $display("Predicted %0d empty messages, %0d length errors, %0d aborts; %0d mismatches.",
                 event_tally[EV_EMPTY], event_tally[EV_ERROR], event_tally[EV_ABORT],
                 error_count);
        if ((error_count == 0) && (expected_results.size() == 0)) begin
            $display("content_length_message_deframer_top test passed");
        end else begin
            $display("content_length_message_deframer_top test failed");
        end
        $finish;
    end

endmodule
